// ----- rtl/core/wbg_pkg.sv -----
// White-balance gain block: shared widths, constants and types.
// No dependencies; imported by wbg_div and the top level.
`timescale 1ns / 1ps

package wbg_pkg;

   localparam int RATIO_W      = 10;
   localparam int CORR_W       = 11;
   localparam int PROD_W       = 21;
   localparam int VAL_W        = 20;
   localparam int BASE_W       = 10;
   localparam int GNUM_W       = 30;
   localparam int GAIN_W       = 16;
   localparam int LIGHT_SHIFT  = 10;
   localparam int UNITY_SHIFT  = 10;
   localparam int CSR_IDX_W    = 1;

   localparam int SCALE        = 1000;
   localparam int UNITY        = 1024;
   localparam int LIGHT_OFFSET = 512;

   localparam int LANE_R       = 0;
   localparam int LANE_G       = 1;
   localparam int LANE_B       = 2;
   localparam int RATIO_LANES  = 2;
   localparam int GAIN_LANES   = 3;

   localparam logic [RATIO_W-1:0] TYPICAL_RG_RESET = RATIO_W'(301);
   localparam logic [RATIO_W-1:0] TYPICAL_BG_RESET = RATIO_W'(328);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TYPICAL_RG = 1'b0,
      CSR_TYPICAL_BG = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

// ----- rtl/core/wbg_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, several lanes in step.
// Depends on wbg_pkg for the pipeline control struct.
`timescale 1ns / 1ps

module wbg_div import wbg_pkg::*; #(
   parameter int LANES  = RATIO_LANES,
   parameter int NUM_W  = VAL_W,
   parameter int DEN_W  = CORR_W,
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  pipe_ctl_type                   ctl_in,
   input  logic [LANES-1:0][NUM_W-1:0]    num,
   input  logic [LANES-1:0][DEN_W-1:0]    den,
   input  logic [SIDE_W-1:0]              side_in,
   output logic                           valid_out,
   output logic [LANES-1:0][NUM_W-1:0]    quo,
   output logic [SIDE_W-1:0]              side_out
);

   logic [NUM_W-1:0]  valid_ff;
   logic [SIDE_W-1:0] side_ff  [NUM_W];
   logic [NUM_W-1:0]  qn_ff    [NUM_W][LANES];
   logic [NUM_W-1:0]  qn_in    [NUM_W][LANES];
   logic [NUM_W-1:0]  qn_prev  [NUM_W][LANES];
   logic [DEN_W-1:0]  rem_prev [NUM_W][LANES];
   logic [DEN_W-1:0]  den_cur  [NUM_W][LANES];
   logic [DEN_W-1:0]  rem_ff   [NUM_W-1][LANES];
   logic [DEN_W-1:0]  rem_in   [NUM_W-1][LANES];
   logic [DEN_W-1:0]  den_ff   [NUM_W-1][LANES];

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DEN_W:0] trial;
         logic           ge;

         if (s == 0) begin : g_first
            assign rem_prev[s][l] = '0;
            assign den_cur[s][l]  = den[l];
            assign qn_prev[s][l]  = num[l];
         end else begin : g_next
            assign rem_prev[s][l] = rem_ff[s-1][l];
            assign den_cur[s][l]  = den_ff[s-1][l];
            assign qn_prev[s][l]  = qn_ff[s-1][l];
         end

         assign trial = {rem_prev[s][l], qn_prev[s][l][NUM_W-1]};
         assign ge    = trial >= {1'b0, den_cur[s][l]};
         assign qn_in[s][l] = {qn_prev[s][l][NUM_W-2:0], ge};

         if (s < NUM_W - 1) begin : g_rem
            logic [DEN_W-1:0] diff;
            assign diff = trial[DEN_W-1:0] - den_cur[s][l];
            assign rem_in[s][l] = ge ? diff : trial[DEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl_in.advance) begin
         valid_ff <= {valid_ff[NUM_W-2:0], ctl_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < NUM_W; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int s = 0; s < NUM_W; s++) begin
            for (int l = 0; l < LANES; l++) begin
               qn_ff[s][l] <= qn_in[s][l];
            end
         end
         for (int s = 0; s < NUM_W - 1; s++) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= rem_in[s][l];
               den_ff[s][l] <= den_cur[s][l];
            end
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo[l] = qn_ff[NUM_W-1][l];
      end
   end

   assign valid_out = valid_ff[NUM_W-1];
   assign side_out  = side_ff[NUM_W-1];

endmodule

// ----- rtl/core/white_balance_gain_from_otp_ratios.sv -----
// White-balance gain calculator, top level: input register, light correction,
// ratio and gain dividers (wbg_div) and the saturating output register. Uses wbg_pkg.
`timescale 1ns / 1ps

// Takes one word per cycle unless req_stall is high and returns its gains through one input
// register, one light-correction stage, a 20-stage ratio divider, one base-select
// stage, a 30-stage gain divider and the output register. The whole pipeline holds
// while a result waits under rsp_stall, so req_stall follows rsp_stall whenever a
// result is waiting. The typical ratios are read live by the correction stage; write
// them only with the pipeline empty.
module white_balance_gain_from_otp_ratios import wbg_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [RATIO_W-1:0]   csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [RATIO_W-1:0]   req_measured_rg,
   input  logic [RATIO_W-1:0]   req_measured_bg,
   input  logic [RATIO_W-1:0]   req_light_factor_rg,
   input  logic [RATIO_W-1:0]   req_light_factor_bg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [GAIN_W-1:0]    rsp_red_gain,
   output logic [GAIN_W-1:0]    rsp_green_gain,
   output logic [GAIN_W-1:0]    rsp_blue_gain,
   output logic                 rsp_red_apply,
   output logic                 rsp_green_apply,
   output logic                 rsp_blue_apply,
   output logic                 rsp_divide_error
);

   logic advance;

   logic [RATIO_W-1:0] typ_rg_ff, typ_bg_ff;

   // input register
   logic                             s0_valid_ff;
   logic [RATIO_LANES-1:0][RATIO_W-1:0] s0_meas_ff, s0_fact_ff;

   // light correction
   logic [RATIO_LANES-1:0][PROD_W-1:0] s1_prod;
   logic [RATIO_LANES-1:0][CORR_W-1:0] s1_corr_in, s1_corr_ff;
   logic [RATIO_LANES-1:0][VAL_W-1:0]  s1_num_in, s1_num_ff;
   logic                               s1_err_in, s1_err_ff, s1_valid_ff;

   // ratio divider
   logic                               da_valid, da_err;
   logic [RATIO_LANES-1:0][VAL_W-1:0]  da_quo;

   // base select
   logic [VAL_W-1:0]                   s2_min;
   logic                               s2_below;
   logic [BASE_W-1:0]                  s2_base_in, s2_base_ff;
   logic [GAIN_LANES-1:0][GNUM_W-1:0]  s2_num_in, s2_num_ff;
   logic                               s2_err_in, s2_err_ff, s2_valid_ff;

   // gain divider
   logic                               db_valid, db_err;
   logic [GAIN_LANES-1:0][GNUM_W-1:0]  db_quo;

   // output register
   logic [GAIN_LANES-1:0][GAIN_W-1:0]  gain_in, gain_ff;
   logic [GAIN_LANES-1:0]              apply_in, apply_ff;
   logic                               rsp_valid_ff, err_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         typ_rg_ff <= TYPICAL_RG_RESET;
         typ_bg_ff <= TYPICAL_BG_RESET;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_TYPICAL_RG: typ_rg_ff <= csr_wdata;
            CSR_TYPICAL_BG: typ_bg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_valid;
         s1_valid_ff  <= s0_valid_ff;
         s2_valid_ff  <= da_valid;
         rsp_valid_ff <= db_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_meas_ff[0] <= req_measured_rg;
         s0_meas_ff[1] <= req_measured_bg;
         s0_fact_ff[0] <= req_light_factor_rg;
         s0_fact_ff[1] <= req_light_factor_bg;
      end
   end

   // corrected ratio = ratio * (factor + 512) / 1024, factor of zero bypasses
   always_comb begin
      for (int l = 0; l < RATIO_LANES; l++) begin
         s1_prod[l] = PROD_W'(s0_meas_ff[l])
                    * (PROD_W'(s0_fact_ff[l]) + PROD_W'(LIGHT_OFFSET));
         s1_corr_in[l] = (s0_fact_ff[l] == '0) ? CORR_W'(s0_meas_ff[l])
                                               : s1_prod[l][PROD_W-1:LIGHT_SHIFT];
      end
      s1_num_in[0] = VAL_W'(typ_rg_ff) * VAL_W'(SCALE);
      s1_num_in[1] = VAL_W'(typ_bg_ff) * VAL_W'(SCALE);
      s1_err_in    = (s1_corr_in[0] == '0) || (s1_corr_in[1] == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_corr_ff <= s1_corr_in;
         s1_num_ff  <= s1_num_in;
         s1_err_ff  <= s1_err_in;
      end
   end

   wbg_div #(
      .LANES  (RATIO_LANES),
      .NUM_W  (VAL_W),
      .DEN_W  (CORR_W),
      .SIDE_W (1)
   ) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (pipe_ctl_type'{advance: advance, valid: s1_valid_ff}),
      .num       (s1_num_ff),
      .den       (s1_corr_ff),
      .side_in   (s1_err_ff),
      .valid_out (da_valid),
      .quo       (da_quo),
      .side_out  (da_err)
   );

   // base is the smaller value when either is below scale, else scale
   always_comb begin
      s2_below   = (da_quo[0] < VAL_W'(SCALE)) || (da_quo[1] < VAL_W'(SCALE));
      s2_min     = (da_quo[0] < da_quo[1]) ? da_quo[0] : da_quo[1];
      s2_base_in = s2_below ? BASE_W'(s2_min) : BASE_W'(SCALE);
      s2_err_in  = da_err || (s2_base_in == '0);
      s2_num_in[LANE_R] = GNUM_W'(da_quo[0]) << UNITY_SHIFT;
      s2_num_in[LANE_G] = GNUM_W'(SCALE) << UNITY_SHIFT;
      s2_num_in[LANE_B] = GNUM_W'(da_quo[1]) << UNITY_SHIFT;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_base_ff <= s2_base_in;
         s2_num_ff  <= s2_num_in;
         s2_err_ff  <= s2_err_in;
      end
   end

   wbg_div #(
      .LANES  (GAIN_LANES),
      .NUM_W  (GNUM_W),
      .DEN_W  (BASE_W),
      .SIDE_W (1)
   ) u_gain_div (
      .clock     (clock),
      .reset     (reset),
      .ctl_in    (pipe_ctl_type'{advance: advance, valid: s2_valid_ff}),
      .num       (s2_num_ff),
      .den       ({GAIN_LANES{s2_base_ff}}),
      .side_in   (s2_err_ff),
      .valid_out (db_valid),
      .quo       (db_quo),
      .side_out  (db_err)
   );

   // saturate, flag gains above unity; an error clears everything
   always_comb begin
      for (int l = 0; l < GAIN_LANES; l++) begin
         if (db_err) begin
            gain_in[l]  = '0;
            apply_in[l] = 1'b0;
         end else begin
            gain_in[l]  = (|db_quo[l][GNUM_W-1:GAIN_W]) ? '1 : db_quo[l][GAIN_W-1:0];
            apply_in[l] = db_quo[l] > GNUM_W'(UNITY);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gain_ff  <= gain_in;
         apply_ff <= apply_in;
         err_ff   <= db_err;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_red_gain     = gain_ff[LANE_R];
   assign rsp_green_gain   = gain_ff[LANE_G];
   assign rsp_blue_gain    = gain_ff[LANE_B];
   assign rsp_red_apply    = apply_ff[LANE_R];
   assign rsp_green_apply  = apply_ff[LANE_G];
   assign rsp_blue_apply   = apply_ff[LANE_B];
   assign rsp_divide_error = err_ff;

   a_error_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_error |->
         !rsp_red_apply && !rsp_green_apply && !rsp_blue_apply &&
         rsp_red_gain == '0 && rsp_green_gain == '0 && rsp_blue_gain == '0)
      else $error("divide error with non-zero gains or apply flags");

   // base never exceeds scale, so green is at least unity
   a_green_floor : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_error |->
         rsp_green_gain >= GAIN_W'(UNITY) && (rsp_red_gain >= GAIN_W'(UNITY) ||
         rsp_blue_gain >= GAIN_W'(UNITY) || rsp_green_gain > GAIN_W'(UNITY)))
      else $error("gain below unity where base selection forbids it");

   a_saturate_applies : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_divide_error && rsp_red_gain == '1 |-> rsp_red_apply)
      else $error("saturated red gain without apply flag");

endmodule
